// File: rtl/core/lcs_pkg.sv
// shared types and constants for the lcd command sequencer
package lcs_pkg;

   localparam int QDEPTH    = 4;
   localparam int QPTR_W    = $clog2(QDEPTH);
   localparam int QCNT_W    = $clog2(QDEPTH + 1);
   localparam int WIN_BEATS = 10;
   localparam int STEP_W    = $clog2(WIN_BEATS);

   localparam logic [7:0] CMD_COLUMN_SET = 8'h2A;
   localparam logic [7:0] CMD_PAGE_SET   = 8'h2B;
   localparam logic [7:0] TABLE_END      = 8'h00;

   typedef enum logic [2:0] {
      OP_INIT   = 3'd0,
      OP_WINDOW = 3'd1,
      OP_PIXEL  = 3'd2,
      OP_CMD    = 3'd3,
      OP_DATA   = 3'd4
   } opcode_type;

   typedef enum logic [1:0] {
      JOB_SINGLE = 2'd0,
      JOB_PIXEL  = 2'd1,
      JOB_WINDOW = 2'd2
   } job_kind_type;

   // window steps
   typedef enum logic [STEP_W-1:0] {
      ST_COL_CMD = 4'd0,
      ST_XS_HI   = 4'd1,
      ST_XS_LO   = 4'd2,
      ST_XE_HI   = 4'd3,
      ST_XE_LO   = 4'd4,
      ST_PAGE_CMD = 4'd5,
      ST_YS_HI   = 4'd6,
      ST_YS_LO   = 4'd7,
      ST_YE_HI   = 4'd8,
      ST_YE_LO   = 4'd9
   } win_step_type;

   typedef struct packed {
      job_kind_type kind;
      logic [7:0]   bus_byte;
      logic         is_data;
      logic         is_write;
      logic         init_done;
      logic [15:0]  w0;   // x start or pixel color
      logic [15:0]  w1;   // x end
      logic [15:0]  w2;   // y start
      logic [15:0]  w3;   // y end
   } job_type;

   typedef struct packed {
      logic       valid;
      logic       full;
   } queue_status_type;

   typedef struct packed {
      logic [7:0] bus_byte;
      logic       is_data;
      logic       is_write;
      logic       init_done;
      logic       last;
   } beat_type;

endpackage

// File: rtl/core/lcs_front.sv
// front end: accepts requests, runs the init table parser, builds jobs
module lcs_front
   import lcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [2:0]       req_opcode,
   input  logic [7:0]       req_byte_value,
   input  logic [15:0]      req_x_start,
   input  logic [15:0]      req_y_start,
   input  logic [15:0]      req_width,
   input  logic [15:0]      req_height,
   input  logic [15:0]      req_pixel_color,
   input  queue_status_type q_status,
   output logic             q_push,
   output job_type          q_job
);

   typedef enum logic [2:0] {
      PH_CMD   = 3'b001,
      PH_COUNT = 3'b010,
      PH_ARG   = 3'b100
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] args_ff, args_in;
   logic       accept;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      phase_in        = phase_ff;
      args_in         = args_ff;
      q_push          = 1'b0;
      q_job           = '0;
      q_job.kind      = JOB_SINGLE;
      q_job.bus_byte  = req_byte_value;
      q_job.is_write  = 1'b1;
      if (accept) begin
         case (opcode_type'(req_opcode))
            OP_INIT: begin
               case (phase_ff)
                  PH_COUNT: begin
                     args_in  = req_byte_value;
                     phase_in = (req_byte_value == 8'd0) ? PH_CMD : PH_ARG;
                  end
                  PH_ARG: begin
                     q_push        = 1'b1;
                     q_job.is_data = 1'b1;
                     args_in       = args_ff - 8'd1;
                     if (args_in == 8'd0) begin
                        phase_in = PH_CMD;
                     end
                  end
                  default: begin
                     q_push = 1'b1;
                     if (req_byte_value == TABLE_END) begin
                        q_job.is_write  = 1'b0;
                        q_job.init_done = 1'b1;
                        phase_in        = PH_CMD;
                     end else begin
                        phase_in = PH_COUNT;
                     end
                  end
               endcase
            end
            OP_WINDOW: begin
               q_push     = 1'b1;
               q_job.kind = JOB_WINDOW;
               q_job.w0   = req_x_start;
               q_job.w1   = req_x_start + req_width - 16'd1;
               q_job.w2   = req_y_start;
               q_job.w3   = req_y_start + req_height - 16'd1;
            end
            OP_PIXEL: begin
               q_push     = 1'b1;
               q_job.kind = JOB_PIXEL;
               q_job.w0   = req_pixel_color;
            end
            OP_CMD: begin
               q_push = 1'b1;
            end
            OP_DATA: begin
               q_push        = 1'b1;
               q_job.is_data = 1'b1;
            end
            default: begin
               q_push = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_CMD;
         args_ff  <= 8'd0;
      end else begin
         phase_ff <= phase_in;
         args_ff  <= args_in;
      end
   end

endmodule

// File: rtl/core/lcs_queue.sv
// small job queue between front and back
module lcs_queue
   import lcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output queue_status_type status,
   output job_type          head_job
);

   job_type           entry_ff [QDEPTH];
   logic [QPTR_W-1:0] head_ff, head_in;
   logic [QPTR_W-1:0] tail_ff, tail_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              do_push, do_pop;

   assign status.valid = (count_ff != '0);
   assign status.full  = (count_ff == QCNT_W'(QDEPTH));
   assign head_job     = entry_ff[head_ff];
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;

   always_comb begin
      head_in  = do_pop ? head_ff + QPTR_W'(1) : head_ff;
      tail_in  = do_push ? tail_ff + QPTR_W'(1) : tail_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[tail_ff] <= push_job;
      end
   end

endmodule

// File: rtl/core/lcs_back.sv
// back end: expands jobs into bus beats through an output register
module lcs_back
   import lcs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  queue_status_type q_status,
   input  job_type          q_job,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_bus_byte,
   output logic             rsp_is_data,
   output logic             rsp_is_write,
   output logic             rsp_init_done,
   output logic             rsp_last
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic              valid_ff, valid_in;
   beat_type          beat_ff, beat_in;
   logic              load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      beat_in           = '0;
      beat_in.is_data   = 1'b1;
      beat_in.is_write  = 1'b1;
      case (q_job.kind)
         JOB_PIXEL: begin
            beat_in.bus_byte = step_ff[0] ? q_job.w0[7:0] : q_job.w0[15:8];
            beat_in.last     = (step_ff == STEP_W'(1));
         end
         JOB_WINDOW: begin
            beat_in.last = (step_ff == ST_YE_LO);
            case (win_step_type'(step_ff))
               ST_COL_CMD: begin
                  beat_in.bus_byte = CMD_COLUMN_SET;
                  beat_in.is_data  = 1'b0;
               end
               ST_XS_HI:    beat_in.bus_byte = q_job.w0[15:8];
               ST_XS_LO:    beat_in.bus_byte = q_job.w0[7:0];
               ST_XE_HI:    beat_in.bus_byte = q_job.w1[15:8];
               ST_XE_LO:    beat_in.bus_byte = q_job.w1[7:0];
               ST_PAGE_CMD: begin
                  beat_in.bus_byte = CMD_PAGE_SET;
                  beat_in.is_data  = 1'b0;
               end
               ST_YS_HI:    beat_in.bus_byte = q_job.w2[15:8];
               ST_YS_LO:    beat_in.bus_byte = q_job.w2[7:0];
               ST_YE_HI:    beat_in.bus_byte = q_job.w3[15:8];
               ST_YE_LO:    beat_in.bus_byte = q_job.w3[7:0];
               default:     beat_in.bus_byte = q_job.w3[7:0];
            endcase
         end
         default: begin
            beat_in.bus_byte  = q_job.bus_byte;
            beat_in.is_data   = q_job.is_data;
            beat_in.is_write  = q_job.is_write;
            beat_in.init_done = q_job.init_done;
            beat_in.last      = 1'b1;
         end
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      step_in  = step_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = q_status.valid;
         if (q_status.valid) begin
            if (beat_in.last) begin
               q_pop   = 1'b1;
               step_in = '0;
            end else begin
               step_in = step_ff + STEP_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         step_ff  <= step_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load && q_status.valid) begin
         beat_ff <= beat_in;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_bus_byte  = beat_ff.bus_byte;
   assign rsp_is_data   = beat_ff.is_data;
   assign rsp_is_write  = beat_ff.is_write;
   assign rsp_init_done = beat_ff.init_done;
   assign rsp_last      = beat_ff.last;

endmodule

// File: rtl/core/lcd_command_sequencer_top.sv
// top level of the lcd command sequencer
// Each request becomes bus beats on rsp_, one byte with a command/data flag per
// beat, up to one beat per cycle from the output register while rsp_ready is
// high. A pixel yields 2 beats, a window 10, an init table byte or raw byte 1;
// a count byte or an unused opcode is accepted and yields no beat. The beat
// rate of the back end sets the throughput; a four-entry job queue lets the
// front keep accepting requests while the back end drains earlier jobs.
module lcd_command_sequencer_top
   import lcs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_opcode,
   input  logic [7:0]  req_byte_value,
   input  logic [15:0] req_x_start,
   input  logic [15:0] req_y_start,
   input  logic [15:0] req_width,
   input  logic [15:0] req_height,
   input  logic [15:0] req_pixel_color,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_bus_byte,
   output logic        rsp_is_data,
   output logic        rsp_is_write,
   output logic        rsp_init_done,
   output logic        rsp_last
);

   queue_status_type q_status;
   logic             q_push;
   logic             q_pop;
   job_type          push_job;
   job_type          head_job;

   lcs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_byte_value  (req_byte_value),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_width       (req_width),
      .req_height      (req_height),
      .req_pixel_color (req_pixel_color),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_job           (push_job)
   );

   lcs_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .status   (q_status),
      .head_job (head_job)
   );

   lcs_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_status      (q_status),
      .q_job         (head_job),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_bus_byte  (rsp_bus_byte),
      .rsp_is_data   (rsp_is_data),
      .rsp_is_write  (rsp_is_write),
      .rsp_init_done (rsp_init_done),
      .rsp_last      (rsp_last)
   );

endmodule

// File: verif/lcd_command_sequencer_checker.sv
// checker for the lcd command sequencer: predicts the bus beats of every request and compares
module lcd_command_sequencer_checker
   import lcs_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [2:0]         req_opcode,
   input  logic [7:0]         req_byte_value,
   input  logic [15:0]        req_x_start,
   input  logic [15:0]        req_y_start,
   input  logic [15:0]        req_width,
   input  logic [15:0]        req_height,
   input  logic [15:0]        req_pixel_color,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [7:0]         rsp_bus_byte,
   input  logic               rsp_is_data,
   input  logic               rsp_is_write,
   input  logic               rsp_init_done,
   input  logic               rsp_last,
   output int unsigned        pending_beats,
   output int unsigned        error_count,
   output int unsigned        beats_checked,
   output int unsigned        init_done_seen
);

   typedef enum logic [1:0] {
      TBL_CMD   = 2'd0,
      TBL_COUNT = 2'd1,
      TBL_ARG   = 2'd2,
      TBL_SPARE = 2'd3
   } table_phase_type;

   table_phase_type table_phase;
   logic [7:0]      table_args_left;
   beat_type        expected_beats[$];

   function automatic void push_beat(input logic [7:0] b, input logic dat, input logic wr,
                                     input logic done);
      beat_type t;
      t.bus_byte  = b;
      t.is_data   = dat;
      t.is_write  = wr;
      t.init_done = done;
      t.last      = 1'b0;
      expected_beats.push_back(t);
   endfunction

   function automatic void push_word(input logic [15:0] w);
      push_beat(w[15:8], 1'b1, 1'b1, 1'b0);
      push_beat(w[7:0], 1'b1, 1'b1, 1'b0);
   endfunction

   function automatic void push_range(input logic [7:0] cmd, input logic [15:0] start,
                                      input logic [15:0] size);
      logic [15:0] stop;
      stop = start + size - 16'd1;
      push_beat(cmd, 1'b0, 1'b1, 1'b0);
      push_word(start);
      push_word(stop);
   endfunction

   function automatic void predict_bus_writes(input logic [2:0] op, input logic [7:0] b,
                                              input logic [15:0] xs, input logic [15:0] ys,
                                              input logic [15:0] w, input logic [15:0] h,
                                              input logic [15:0] color);
      int       queued_at_entry;
      beat_type tail;
      queued_at_entry = expected_beats.size();
      case (op)
         OP_INIT: begin
            case (table_phase)
               TBL_COUNT: begin
                  table_args_left = b;
                  table_phase = (b == 8'd0) ? TBL_CMD : TBL_ARG;
               end
               TBL_ARG: begin
                  push_beat(b, 1'b1, 1'b1, 1'b0);
                  table_args_left = table_args_left - 8'd1;
                  if (table_args_left == 8'd0) begin
                     table_phase = TBL_CMD;
                  end
               end
               default: begin
                  if (b == TABLE_END) begin
                     push_beat(TABLE_END, 1'b0, 1'b0, 1'b1);
                     table_phase = TBL_CMD;
                  end else begin
                     push_beat(b, 1'b0, 1'b1, 1'b0);
                     table_phase = TBL_COUNT;
                  end
               end
            endcase
         end
         OP_WINDOW: begin
            push_range(CMD_COLUMN_SET, xs, w);
            push_range(CMD_PAGE_SET, ys, h);
         end
         OP_PIXEL: push_word(color);
         OP_CMD:   push_beat(b, 1'b0, 1'b1, 1'b0);
         OP_DATA:  push_beat(b, 1'b1, 1'b1, 1'b0);
         default: ;
      endcase
      if (expected_beats.size() > queued_at_entry) begin
         tail = expected_beats.pop_back();
         tail.last = 1'b1;
         expected_beats.push_back(tail);
      end
   endfunction

   function automatic void report_mismatch(input string what, input beat_type want,
                                           input beat_type seen);
      error_count++;
      if (error_count <= 10) begin
         $display("mismatch, %s: expected byte %02h data %0b write %0b done %0b last %0b,",
                  what, want.bus_byte, want.is_data, want.is_write, want.init_done, want.last);
         $display("   got byte %02h data %0b write %0b done %0b last %0b",
                  seen.bus_byte, seen.is_data, seen.is_write, seen.init_done, seen.last);
      end
   endfunction

   always @(posedge clock) begin
      beat_type seen;
      beat_type want;
      if (reset) begin
         table_phase = TBL_CMD;
         table_args_left = 8'd0;
         expected_beats.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            seen.bus_byte  = rsp_bus_byte;
            seen.is_data   = rsp_is_data;
            seen.is_write  = rsp_is_write;
            seen.init_done = rsp_init_done;
            seen.last      = rsp_last;
            beats_checked++;
            if (rsp_init_done === 1'b1) begin
               init_done_seen++;
            end
            if (expected_beats.size() == 0) begin
               report_mismatch("beat with nothing expected", '0, seen);
            end else begin
               want = expected_beats.pop_front();
               if (seen !== want) begin
                  report_mismatch("wrong beat", want, seen);
               end
            end
         end
         if (req_valid && req_ready) begin
            predict_bus_writes(req_opcode, req_byte_value, req_x_start, req_y_start,
                               req_width, req_height, req_pixel_color);
         end
      end
      pending_beats = expected_beats.size();
   end

endmodule

// File: verif/tb_lcd_command_sequencer_top.sv
// testbench top for the lcd command sequencer: request stimulus, bus stalls and verdict
module tb_lcd_command_sequencer_top;
   import lcs_pkg::*;

   localparam logic [2:0] OP_SPARE_FIRST = 3'd5;
   localparam logic [2:0] OP_SPARE_LAST  = 3'd7;
   localparam int         MAX_WAIT       = 14;
   localparam int         RANDOM_ITEMS   = 50;

   typedef enum logic [1:0] {
      AT_CMD   = 2'd0,
      AT_COUNT = 2'd1,
      AT_ARG   = 2'd2
   } table_pos_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [2:0]  req_opcode;
   logic [7:0]  req_byte_value;
   logic [15:0] req_x_start;
   logic [15:0] req_y_start;
   logic [15:0] req_width;
   logic [15:0] req_height;
   logic [15:0] req_pixel_color;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [7:0]  rsp_bus_byte;
   logic        rsp_is_data;
   logic        rsp_is_write;
   logic        rsp_init_done;
   logic        rsp_last;

   int unsigned pending_beats;
   int unsigned error_count;
   int unsigned beats_checked;
   int unsigned init_done_seen;

   bit            req_burst;
   bit            rsp_burst;
   int unsigned   items_sent;
   table_pos_type table_pos;
   int            table_args;

   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   lcd_command_sequencer_top i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_byte_value  (req_byte_value),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_width       (req_width),
      .req_height      (req_height),
      .req_pixel_color (req_pixel_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_is_data     (rsp_is_data),
      .rsp_is_write    (rsp_is_write),
      .rsp_init_done   (rsp_init_done),
      .rsp_last        (rsp_last)
   );

   lcd_command_sequencer_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_opcode      (req_opcode),
      .req_byte_value  (req_byte_value),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_width       (req_width),
      .req_height      (req_height),
      .req_pixel_color (req_pixel_color),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_bus_byte    (rsp_bus_byte),
      .rsp_is_data     (rsp_is_data),
      .rsp_is_write    (rsp_is_write),
      .rsp_init_done   (rsp_init_done),
      .rsp_last        (rsp_last),
      .pending_beats   (pending_beats),
      .error_count     (error_count),
      .beats_checked   (beats_checked),
      .init_done_seen  (init_done_seen)
   );

   function automatic logic [7:0] any_byte();
      return 8'($urandom);
   endfunction

   function automatic logic [15:0] any_word();
      return 16'($urandom);
   endfunction

   function automatic logic [15:0] corner_word();
      case ($urandom_range(0, 3))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic send_request(input logic [2:0] op, input logic [7:0] b,
                               input logic [15:0] xs, input logic [15:0] ys,
                               input logic [15:0] w, input logic [15:0] h,
                               input logic [15:0] color);
      int gap;
      gap = req_burst ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= op;
      req_byte_value  <= b;
      req_x_start     <= xs;
      req_y_start     <= ys;
      req_width       <= w;
      req_height      <= h;
      req_pixel_color <= color;
      do @(posedge clock); while (!req_ready);
      if (op <= OP_DATA) begin
         items_sent++;
      end
   endtask

   task automatic send_raw(input logic [2:0] op, input logic [7:0] b);
      send_request(op, b, any_word(), any_word(), any_word(), any_word(), any_word());
   endtask

   task automatic send_pixel(input logic [15:0] color);
      send_request(OP_PIXEL, any_byte(), any_word(), any_word(), any_word(), any_word(), color);
   endtask

   task automatic send_window(input logic [15:0] xs, input logic [15:0] ys,
                              input logic [15:0] w, input logic [15:0] h);
      send_request(OP_WINDOW, any_byte(), xs, ys, w, h, any_word());
   endtask

   // tracks where the table parser stands so that tables can be started cleanly
   task automatic send_table_byte(input logic [7:0] b);
      case (table_pos)
         AT_COUNT: begin
            table_args = b;
            table_pos = (b == 8'd0) ? AT_CMD : AT_ARG;
         end
         AT_ARG: begin
            table_args--;
            if (table_args == 0) begin
               table_pos = AT_CMD;
            end
         end
         default: table_pos = (b == TABLE_END) ? AT_CMD : AT_COUNT;
      endcase
      send_raw(OP_INIT, b);
   endtask

   task automatic resync_table();
      while (table_pos != AT_CMD) begin
         send_table_byte(table_pos == AT_COUNT ? 8'd0 : any_byte());
      end
   endtask

   task automatic write_table_entry(input logic [7:0] count, input bit mix);
      send_table_byte(8'($urandom_range(1, 255)));
      send_table_byte(count);
      repeat (count) begin
         if (mix && $urandom_range(0, 5) == 0) begin
            send_pixel(any_word());
         end
         send_table_byte(any_byte());
      end
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      do @(negedge clock); while (pending_beats != 0);
      @(posedge clock);
   endtask

   // result side: random stalls before every beat, with stretches of none
   initial begin
      int stall;
      rsp_ready <= 1'b0;
      forever begin
         stall = rsp_burst ? 0 : $urandom_range(0, MAX_WAIT);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   initial begin
      int unsigned random_base;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_opcode      <= OP_INIT;
      req_byte_value  <= 8'd0;
      req_x_start     <= 16'd0;
      req_y_start     <= 16'd0;
      req_width       <= 16'd0;
      req_height      <= 16'd0;
      req_pixel_color <= 16'd0;
      req_burst = 1'b0;
      rsp_burst = 1'b0;
      items_sent = 0;
      table_pos = AT_CMD;
      table_args = 0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // init table: zero count, zero and all-ones arguments, interleaved pixel
      send_table_byte(8'h01);
      send_table_byte(8'h00);
      send_table_byte(8'hFF);
      send_table_byte(8'h02);
      send_table_byte(8'h00);
      send_table_byte(8'hFF);
      send_table_byte(8'h36);
      send_table_byte(8'h01);
      send_pixel(16'h0000);
      send_table_byte(8'h48);
      send_table_byte(TABLE_END);
      send_table_byte(TABLE_END);
      // window end wrap and size zero
      send_window(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
      send_window(16'hFFFF, 16'h1234, 16'h0001, 16'h0002);
      send_window(16'h8000, 16'h0000, 16'h8000, 16'h0001);
      send_pixel(16'hFFFF);
      send_pixel(16'hA55A);
      send_raw(OP_CMD, 8'h00);
      send_raw(OP_CMD, 8'hFF);
      send_raw(OP_DATA, 8'h00);
      send_raw(OP_DATA, 8'hFF);
      for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++) begin
         send_raw(3'(op), any_byte());
      end
      drain();

      // one long argument list to exercise the top bit of the argument counter
      req_burst = 1'b1;
      rsp_burst = 1'b1;
      write_table_entry(8'd128, 1'b0);
      send_table_byte(TABLE_END);
      drain();

      req_burst = 1'b0;
      rsp_burst = 1'b0;
      random_base = items_sent;
      while (items_sent - random_base < RANDOM_ITEMS) begin
         if ($urandom_range(0, 9) == 0) begin
            req_burst = ($urandom_range(0, 3) == 0);
            rsp_burst = ($urandom_range(0, 3) == 0);
         end
         if ($urandom_range(0, 19) == 0) begin
            drain();
         end
         case ($urandom_range(0, 9))
            0, 1, 2, 3: begin
               resync_table();
               repeat ($urandom_range(1, 4)) begin
                  write_table_entry(8'($urandom_range(0, 4)), 1'b1);
               end
               if ($urandom_range(0, 3) != 0) begin
                  send_table_byte(TABLE_END);
               end
            end
            4, 5: repeat ($urandom_range(1, 6)) send_pixel(any_word());
            6: send_window(corner_word(), corner_word(), corner_word(), corner_word());
            7: send_raw($urandom_range(0, 1) ? OP_CMD : OP_DATA, any_byte());
            default: begin
               // broken tables and unused opcodes
               repeat ($urandom_range(1, 3)) begin
                  if ($urandom_range(0, 1) == 0) begin
                     send_table_byte(table_pos == AT_COUNT ? 8'($urandom_range(0, 7))
                                                           : any_byte());
                  end else begin
                     send_raw(3'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST)), any_byte());
                  end
               end
            end
         endcase
      end

      req_valid <= 1'b0;
      do @(negedge clock); while (pending_beats != 0);
      repeat (20) @(posedge clock);
      $display("run covered %0d requests (table, window, pixel, raw) and %0d checked bus beats,",
               items_sent, beats_checked);
      $display("including %0d init-done reports, under random and absent stalls",
               init_done_seen);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule

// File: files.f
rtl/core/lcs_pkg.sv
rtl/core/lcs_front.sv
rtl/core/lcs_queue.sv
rtl/core/lcs_back.sv
rtl/core/lcd_command_sequencer_top.sv
verif/lcd_command_sequencer_checker.sv
verif/tb_lcd_command_sequencer_top.sv
